FILE: sv/cst_pkg.sv
`default_nettype none
package cst_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int COL_W       = 8;
	localparam int CNT_W       = COL_W + 1;
	localparam int ROW_W       = 24;
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 48;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_END   = 8'h00;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ERROR = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       content_byte;
		logic             content_valid;
		logic             field_end;
		logic             record_end;
		logic [COL_W-1:0] column_index;
		logic [ROW_W-1:0] rows_done;
		logic [1:0]       status;
		logic             last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage
`default_nettype wire

FILE: sv/cst_parser.sv
`default_nettype none
module cst_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire cst_pkg::in_item_t in_item,
	output cst_pkg::push_t         push
);
	import cst_pkg::*;

	typedef enum logic [2:0] {
		M_START,
		M_PLAIN,
		M_QUOTED,
		M_QSEEN,
		M_CRPEND,
		M_QCR,
		M_FINISHED,
		M_ERROR
	} mode_t;

	typedef enum logic [2:0] {
		A_NONE,
		A_CONTENT,
		A_FIELD,
		A_RECORD,
		A_FAIL,
		A_DONE
	} act_t;

	mode_t            mode_q, mode_d, mode_eff, act_mode;
	act_t             act;
	logic [COL_W-1:0] cols_q, cols_d;
	logic [CNT_W-1:0] exp_q, exp_d, col_inc;
	logic [ROW_W-1:0] rows_q, rows_d;
	logic [7:0]       b, act_byte;
	logic             eot, pre, do_plain, rec_final, fail_now, main_emit;
	result_t          main_r, cr_r;

	always_comb begin
		b         = in_item.text_byte;
		eot       = in_item.end_of_text || (b == CH_END);
		pre       = (mode_q == M_CRPEND) && !(!eot && b == CH_LF);
		mode_eff  = pre ? M_PLAIN : mode_q;
		act       = A_NONE;
		act_mode  = mode_eff;
		act_byte  = b;
		rec_final = 1'b0;
		do_plain  = 1'b0;

		case (mode_eff)
			M_START: begin
				if (eot) begin
					if (cols_q != '0) begin
						act       = A_RECORD;
						rec_final = 1'b1;
					end else if (rows_q == '0) begin
						act = A_FAIL;
					end else begin
						act = A_DONE;
					end
				end else if (b == CH_QUOTE) begin
					act_mode = M_QUOTED;
				end else begin
					do_plain = 1'b1;
				end
			end
			M_PLAIN: begin
				if (eot) begin
					act       = A_RECORD;
					rec_final = 1'b1;
				end else begin
					do_plain = 1'b1;
				end
			end
			M_QUOTED: begin
				if (eot) begin
					act = A_FAIL;
				end else if (b == CH_QUOTE) begin
					act_mode = M_QSEEN;
				end else begin
					act = A_CONTENT;
				end
			end
			M_QSEEN: begin
				if (eot) begin
					act       = A_RECORD;
					rec_final = 1'b1;
				end else if (b == CH_QUOTE) begin
					act      = A_CONTENT;
					act_mode = M_QUOTED;
				end else if (b == CH_COMMA) begin
					act = A_FIELD;
				end else if (b == CH_LF) begin
					act = A_RECORD;
				end else if (b == CH_CR) begin
					act_mode = M_QCR;
				end else begin
					act = A_FAIL;
				end
			end
			M_QCR: begin
				act = (!eot && b == CH_LF) ? A_RECORD : A_FAIL;
			end
			M_CRPEND: begin
				act = A_RECORD;
			end
			M_FINISHED: begin
				act = A_DONE;
			end
			default: begin
				act = A_FAIL;
			end
		endcase

		if (do_plain) begin
			case (b)
				CH_COMMA: act = A_FIELD;
				CH_LF:    act = A_RECORD;
				CH_CR:    act_mode = M_CRPEND;
				default: begin
					act      = A_CONTENT;
					act_mode = M_PLAIN;
				end
			endcase
		end
	end

	always_comb begin
		col_inc              = CNT_W'(cols_q) + CNT_W'(1);
		main_r               = '0;
		main_r.content_byte  = act_byte;
		main_r.column_index  = cols_q;
		main_r.rows_done     = rows_q;
		main_r.status        = ST_OK;
		main_emit            = 1'b1;
		fail_now             = 1'b0;
		cols_d               = cols_q;
		rows_d               = rows_q;
		exp_d                = exp_q;
		mode_d               = act_mode;

		case (act)
			A_NONE: begin
				main_emit = 1'b0;
			end
			A_CONTENT: begin
				main_r.content_valid = 1'b1;
			end
			A_FIELD: begin
				if (col_inc >= CNT_W'(MAX_COLUMNS)) begin
					fail_now = 1'b1;
				end else begin
					main_r.field_end = 1'b1;
					cols_d           = col_inc[COL_W-1:0];
					mode_d           = M_START;
				end
			end
			A_RECORD: begin
				if (exp_q != '0 && col_inc != exp_q) begin
					fail_now = 1'b1;
				end else begin
					if (exp_q == '0) begin
						exp_d = col_inc;
					end
					if (rows_q != '1) begin
						rows_d = rows_q + ROW_W'(1);
					end
					main_r.rows_done  = rows_d;
					main_r.field_end  = 1'b1;
					main_r.record_end = 1'b1;
					main_r.status     = rec_final ? ST_DONE : ST_OK;
					mode_d            = rec_final ? M_FINISHED : M_START;
					cols_d            = '0;
				end
			end
			A_DONE: begin
				main_r.status = ST_DONE;
				mode_d        = M_FINISHED;
			end
			default: begin
				fail_now = 1'b1;
			end
		endcase

		if (fail_now) begin
			main_r.field_end  = 1'b0;
			main_r.record_end = 1'b0;
			main_r.status     = ST_ERROR;
			mode_d            = M_ERROR;
			cols_d            = cols_q;
			rows_d            = rows_q;
			exp_d             = exp_q;
		end
		if (!main_r.content_valid) begin
			main_r.content_byte = '0;
		end
		main_r.last_of_run = 1'b1;

		cr_r               = '0;
		cr_r.content_byte  = CH_CR;
		cr_r.content_valid = 1'b1;
		cr_r.column_index  = cols_q;
		cr_r.rows_done     = rows_q;
		cr_r.status        = ST_OK;
		cr_r.last_of_run   = !main_emit;

		push.r0  = pre ? cr_r : main_r;
		push.r1  = main_r;
		push.cnt = fire ? (2'(pre) + 2'(main_emit)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_START;
			cols_q <= '0;
			exp_q  <= '0;
			rows_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			cols_q <= cols_d;
			exp_q  <= exp_d;
			rows_q <= rows_d;
		end
	end

endmodule
`default_nettype wire

FILE: sv/cst_result_fifo.sv
`default_nettype none
module cst_result_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cst_pkg::push_t  push,
	output logic                 room,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output cst_pkg::result_t     out_item
);
	import cst_pkg::*;

	result_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [FILL_W-1:0] fill_q;
	logic              pop;

	assign out_valid = (fill_q != '0);
	assign out_item  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room      = (fill_q <= FILL_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + PTR_W'(push.cnt);
			rd_q   <= rd_q + PTR_W'(pop);
			fill_q <= fill_q + FILL_W'(push.cnt) - FILL_W'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: sv/csv_stream_tokenizer_core.sv
// CSV tokenizer. Feed CSV text on the slave stream, one byte per request:
// s_axis_tdata carries the text byte, s_axis_tuser set marks end of text
// (the byte is then ignored; a zero byte also ends the text).
// The master stream gives result requests: field content bytes with field-end
// and record-end marks, column index, completed row count and status
// (0 ok, 1 format error, 2 text finished). m_axis_tlast marks the last result
// caused by one input byte; a byte causes zero, one or two results.
// A taken byte waits in the input register; once the queue has room the mode
// update turns it into its results, which are written into the result queue
// together and offered on the master side, the second result of a byte behind
// the first. Throughput: one byte per cycle while the queue has room;
// the master side moves one result per cycle while the receiver is ready.
// The rate is set by the mode update between the input register and a
// four-entry result queue.
// Reset clears the parse state, counters and queue; the first record then
// fixes the column count again.
// When the receiver stalls, results wait in the queue; when fewer than two
// queue entries are free, a held byte stalls and the slave side takes no more.
`default_nettype none
module csv_stream_tokenizer_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [cst_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] text_byte
	input  wire logic                           s_axis_tuser,  // [0] end_of_text
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [7:0] content_byte, [8] content_valid, [9] field_end, [10] record_end,
	// [18:11] column_index, [42:19] rows_done, [44:43] status, [47:45] zero
	output logic [cst_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                m_axis_tlast   // last_of_run
);
	import cst_pkg::*;

	in_item_t in_s1;
	logic     in_valid_s1, fire, room;
	push_t    push;
	result_t  out_item;

	assign fire          = in_valid_s1 && room;
	assign s_axis_tready = !in_valid_s1 || fire;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_s1.text_byte   <= s_axis_tdata;
			in_s1.end_of_text <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	cst_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_item (in_s1),
		.push    (push)
	);

	cst_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = {3'b000, out_item.status, out_item.rows_done, out_item.column_index,
		out_item.record_end, out_item.field_end, out_item.content_valid, out_item.content_byte};
	assign m_axis_tlast = out_item.last_of_run;

endmodule
`default_nettype wire

FILE: sv/cst_checker.sv
`default_nettype none
module cst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	import cst_pkg::*;

	logic unused_in;
	assign unused_in = s_axis_tvalid ^ s_axis_tready ^ s_axis_tuser ^ (^s_axis_tdata);

	// hold a stalled result request
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[44:43] == ST_ERROR |->
		!m_axis_tdata[8] && !m_axis_tdata[9] && !m_axis_tdata[10] && m_axis_tlast)
		else $error("error result carries marks");

	a_record_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[9] && !m_axis_tdata[8])
		else $error("record end without field end");

	a_content: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[8] |->
		!m_axis_tdata[9] && m_axis_tdata[44:43] == ST_OK)
		else $error("content result with mark or status");

	a_no_content_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'h00)
		else $error("non-content result with nonzero byte");

endmodule

bind csv_stream_tokenizer_core cst_checker u_cst_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_csv_stream_tokenizer_core.sv
`timescale 1ns / 1ps
module tb_csv_stream_tokenizer_core;
	import cst_pkg::*;

	localparam int REC_FIELDS       = 3;
	localparam int SINK_HOLD_CYCLES = 64;
	localparam int STUCK_LIMIT      = 4000;
	localparam int DRAIN_CYCLES     = 10;
	localparam int DIR_ROWS         = 29;

	typedef enum logic [2:0] {
		PM_START, PM_PLAIN, PM_QUOTED, PM_QSEEN, PM_CRPEND, PM_QCR, PM_FINISHED, PM_ERROR
	} parse_mode_e;

	typedef enum int {
		END_CLEAN, END_ZERO_BYTE, END_COMMA_EOT, END_QUOTED_EOT, END_OPEN_QUOTE,
		END_QUOTE_JUNK, END_QUOTE_CR, END_MISMATCH, END_EMPTY_LINE, END_TOO_WIDE
	} text_end_e;

	typedef struct {
		logic [7:0] text;
		bit         typed;
		result_t    res;
	} dir_row_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] text_byte
	logic        s_axis_tuser  = 1'b0;   // [0] end_of_text
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] content_byte, [8] content_valid, [9] field_end, [10] record_end,
	// [18:11] column_index, [42:19] rows_done, [44:43] status, [47:45] zero
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;

	parse_mode_e pmode         = PM_START;
	logic [8:0]  cols_seen     = '0;
	logic [8:0]  cols_expected = '0;
	logic [23:0] row_count     = '0;
	logic        sticky_err    = 1'b0;

	result_t step_results[$];
	result_t expected_results[$];

	int  src_idle_pct    = 0;
	int  sink_idle_pct   = 0;
	bit  sink_hold_req   = 1'b0;
	int  stuck_cycles    = 0;
	int  bad_cnt         = 0;
	int  bytes_sent      = 0;
	int  results_checked = 0;
	text_end_e ending;

	dir_row_t dir_table [DIR_ROWS] = '{
		'{8'h61,    1'b1, '{8'h61, 1'b1, 1'b0, 1'b0, 8'd0, 24'd0, ST_OK, 1'b1}},
		'{8'hFF,    1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 8'd0, 24'd0, ST_OK, 1'b1}},
		'{CH_QUOTE, 1'b1, '{CH_QUOTE, 1'b1, 1'b0, 1'b0, 8'd0, 24'd0, ST_OK, 1'b1}},
		'{CH_COMMA, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 8'd0, 24'd0, ST_OK, 1'b1}},
		'{CH_QUOTE, 1'b0, '0},
		'{CH_COMMA, 1'b0, '0},
		'{CH_CR,    1'b0, '0},
		'{CH_LF,    1'b0, '0},
		'{CH_QUOTE, 1'b0, '0},
		'{CH_QUOTE, 1'b0, '0},
		'{CH_QUOTE, 1'b0, '0},
		'{CH_COMMA, 1'b0, '0},
		'{CH_CR,    1'b0, '0},
		'{CH_LF,    1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 8'd2, 24'd1, ST_OK, 1'b1}},
		'{CH_CR,    1'b0, '0},
		'{CH_COMMA, 1'b0, '0},
		'{CH_QUOTE, 1'b0, '0},
		'{CH_QUOTE, 1'b0, '0},
		'{CH_COMMA, 1'b0, '0},
		'{CH_CR,    1'b0, '0},
		'{8'h78,    1'b0, '0},
		'{CH_LF,    1'b0, '0},
		'{CH_COMMA, 1'b0, '0},
		'{CH_COMMA, 1'b0, '0},
		'{CH_QUOTE, 1'b0, '0},
		'{8'h71,    1'b0, '0},
		'{CH_QUOTE, 1'b0, '0},
		'{CH_CR,    1'b0, '0},
		'{CH_LF,    1'b0, '0}
	};

	csv_stream_tokenizer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void put_result(logic [7:0] b, logic cv, logic fe, logic re);
		result_t r;
		r.content_byte  = b;
		r.content_valid = cv;
		r.field_end     = fe;
		r.record_end    = re;
		r.column_index  = cols_seen[7:0];
		r.rows_done     = row_count;
		r.status        = sticky_err ? ST_ERROR : (pmode == PM_FINISHED ? ST_DONE : ST_OK);
		r.last_of_run   = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void go_error();
		sticky_err = 1'b1;
		pmode      = PM_ERROR;
		put_result(8'h00, 1'b0, 1'b0, 1'b0);
	endfunction

	function automatic void close_field();
		if (cols_seen + 1 >= MAX_COLUMNS) begin
			go_error();
			return;
		end
		put_result(8'h00, 1'b0, 1'b1, 1'b0);
		cols_seen = cols_seen + 9'd1;
		pmode     = PM_START;
	endfunction

	function automatic void close_record(bit at_end);
		logic [8:0] ncols;
		ncols = cols_seen + 9'd1;
		if (cols_expected != 0 && ncols != cols_expected) begin
			go_error();
			return;
		end
		if (cols_expected == 0)
			cols_expected = ncols;
		if (row_count != 24'hFFFFFF)
			row_count = row_count + 24'd1;
		pmode = at_end ? PM_FINISHED : PM_START;
		put_result(8'h00, 1'b0, 1'b1, 1'b1);
		cols_seen = '0;
	endfunction

	function automatic void unquoted_byte(logic [7:0] b);
		if (b == CH_COMMA)
			close_field();
		else if (b == CH_LF)
			close_record(1'b0);
		else if (b == CH_CR)
			pmode = PM_CRPEND;
		else begin
			pmode = PM_PLAIN;
			put_result(b, 1'b1, 1'b0, 1'b0);
		end
	endfunction

	function automatic void tokenize_byte(logic [7:0] b, logic eot_in);
		logic    eot;
		result_t r;
		eot = eot_in || b == CH_END;
		step_results.delete();
		if (sticky_err || pmode == PM_ERROR) begin
			sticky_err = 1'b1;
			pmode      = PM_ERROR;
			put_result(8'h00, 1'b0, 1'b0, 1'b0);
		end else if (pmode == PM_FINISHED) begin
			put_result(8'h00, 1'b0, 1'b0, 1'b0);
		end else begin
			case (pmode)
				PM_START: begin
					if (eot) begin
						if (cols_seen != 0)
							close_record(1'b1);
						else if (row_count == 0)
							go_error();
						else begin
							pmode = PM_FINISHED;
							put_result(8'h00, 1'b0, 1'b0, 1'b0);
						end
					end else if (b == CH_QUOTE)
						pmode = PM_QUOTED;
					else
						unquoted_byte(b);
				end
				PM_PLAIN: begin
					if (eot)
						close_record(1'b1);
					else
						unquoted_byte(b);
				end
				PM_QUOTED: begin
					if (eot)
						go_error();
					else if (b == CH_QUOTE)
						pmode = PM_QSEEN;
					else
						put_result(b, 1'b1, 1'b0, 1'b0);
				end
				PM_QSEEN: begin
					if (eot)
						close_record(1'b1);
					else if (b == CH_QUOTE) begin
						pmode = PM_QUOTED;
						put_result(CH_QUOTE, 1'b1, 1'b0, 1'b0);
					end else if (b == CH_COMMA)
						close_field();
					else if (b == CH_LF)
						close_record(1'b0);
					else if (b == CH_CR)
						pmode = PM_QCR;
					else
						go_error();
				end
				PM_QCR: begin
					if (!eot && b == CH_LF)
						close_record(1'b0);
					else
						go_error();
				end
				PM_CRPEND: begin
					if (!eot && b == CH_LF)
						close_record(1'b0);
					else begin
						pmode = PM_PLAIN;
						put_result(CH_CR, 1'b1, 1'b0, 1'b0);
						if (eot)
							close_record(1'b1);
						else
							unquoted_byte(b);
					end
				end
				default: go_error();
			endcase
		end
		if (step_results.size() != 0) begin
			r = step_results.pop_back();
			r.last_of_run = 1'b1;
			step_results.push_back(r);
		end
	endfunction

	function automatic string fmt_result(result_t r);
		return $sformatf("byte %02h cv %0b fe %0b re %0b col %0d rows %0d st %0d last %0b",
			r.content_byte, r.content_valid, r.field_end, r.record_end,
			r.column_index, r.rows_done, r.status, r.last_of_run);
	endfunction

	task automatic send_request(input logic [7:0] b, input logic eot, input bit typed,
			input result_t typed_res);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= eot;
		do @(posedge clk); while (!s_axis_tready);
		tokenize_byte(b, eot);
		if (typed && step_results.size() != 0) begin
			step_results.delete(step_results.size() - 1);
			step_results.push_back(typed_res);
		end
		foreach (step_results[i])
			expected_results.push_back(step_results[i]);
		bytes_sent++;
	endtask

	task automatic send_text(input logic [7:0] b);
		send_request(b, 1'b0, 1'b0, '0);
	endtask

	task automatic send_eot();
		if ($urandom_range(1))
			send_request(CH_END, 1'b0, 1'b0, '0);
		else
			send_request(8'($urandom_range(255)), 1'b1, 1'b0, '0);
	endtask

	task automatic send_field(input bit quoted);
		int         len;
		logic [7:0] b;
		len = $urandom_range(5);
		if (quoted)
			send_text(CH_QUOTE);
		for (int i = 0; i < len; i++) begin
			if (quoted) begin
				case ($urandom_range(9))
					0: b = CH_QUOTE;
					1: b = CH_COMMA;
					2: b = CH_CR;
					3: b = CH_LF;
					default: b = 8'($urandom_range(255, 1));
				endcase
				if (b == CH_QUOTE)
					send_text(CH_QUOTE);
			end else begin
				case ($urandom_range(9))
					0: b = CH_CR;
					1: b = (i == 0) ? 8'h70 : CH_QUOTE;
					default: begin
						do b = 8'($urandom_range(255, 1));
						while (b == CH_COMMA || b == CH_LF || (i == 0 && b == CH_QUOTE));
					end
				endcase
			end
			send_text(b);
		end
		if (quoted)
			send_text(CH_QUOTE);
	endtask

	task automatic send_fields(input int nfields);
		for (int i = 0; i < nfields; i++) begin
			send_field($urandom_range(99) < 35);
			if (i < nfields - 1)
				send_text(CH_COMMA);
		end
	endtask

	task automatic send_record();
		send_fields(REC_FIELDS);
		if ($urandom_range(1))
			send_text(CH_CR);
		send_text(CH_LF);
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_ending();
		logic [7:0] b;
		case (ending)
			END_CLEAN: send_eot();
			END_ZERO_BYTE: begin
				send_fields(REC_FIELDS);
				send_request(CH_END, 1'b0, 1'b0, '0);
			end
			END_COMMA_EOT: begin
				send_fields(REC_FIELDS - 1);
				send_text(CH_COMMA);
				send_eot();
			end
			END_QUOTED_EOT: begin
				send_fields(REC_FIELDS - 1);
				send_text(CH_COMMA);
				send_field(1'b1);
				send_eot();
			end
			END_OPEN_QUOTE: begin
				send_text(CH_QUOTE);
				send_text(8'h41);
				send_eot();
			end
			END_QUOTE_JUNK: begin
				send_field(1'b1);
				do b = 8'($urandom_range(255, 1));
				while (b == CH_QUOTE || b == CH_COMMA || b == CH_LF || b == CH_CR);
				send_text(b);
			end
			END_QUOTE_CR: begin
				send_field(1'b1);
				send_text(CH_CR);
				if ($urandom_range(1))
					send_eot();
				else begin
					do b = 8'($urandom_range(255, 1));
					while (b == CH_LF);
					send_text(b);
				end
			end
			END_MISMATCH: begin
				send_fields(REC_FIELDS - 1);
				send_text(CH_LF);
			end
			END_EMPTY_LINE: send_text(CH_LF);
			default: repeat (MAX_COLUMNS) send_text(CH_COMMA);
		endcase
	endtask

	initial begin : sink
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				sink_hold_req = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.content_byte  = m_axis_tdata[7:0];
			got.content_valid = m_axis_tdata[8];
			got.field_end     = m_axis_tdata[9];
			got.record_end    = m_axis_tdata[10];
			got.column_index  = m_axis_tdata[18:11];
			got.rows_done     = m_axis_tdata[42:19];
			got.status        = m_axis_tdata[44:43];
			got.last_of_run   = m_axis_tlast;
			results_checked++;
			if (expected_results.size() == 0) begin
				if (bad_cnt < 10)
					$display("unexpected result: %s", fmt_result(got));
				bad_cnt++;
			end else begin
				want = expected_results.pop_front();
				if (got.content_byte !== want.content_byte
						|| got.content_valid !== want.content_valid
						|| got.field_end !== want.field_end
						|| got.record_end !== want.record_end
						|| got.column_index !== want.column_index
						|| got.rows_done !== want.rows_done
						|| got.status !== want.status
						|| got.last_of_run !== want.last_of_run) begin
					if (bad_cnt < 10)
						$display("mismatch: expected %s, got %s",
							fmt_result(want), fmt_result(got));
					bad_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck_cycles <= 0;
		else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				stuck_cycles, expected_results.size());
			$display("tb_csv_stream_tokenizer_core: FAIL");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 14;
		sink_idle_pct = 78;
		foreach (dir_table[i])
			send_request(dir_table[i].text, 1'b0, dir_table[i].typed, dir_table[i].res);
		while (bytes_sent < 260)
			send_record();
		wait_drain();

		src_idle_pct  = 78;
		sink_idle_pct = 14;
		while (bytes_sent < 500)
			send_record();

		ending = text_end_e'($urandom_range(9));

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		sink_hold_req = 1'b1;
		while (bytes_sent < ((ending == END_TOO_WIDE) ? 740 - MAX_COLUMNS : 740))
			send_record();

		send_ending();
		repeat (16)
			send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d text bytes and %0d checked results over three idle mixes,",
			bytes_sent, results_checked);
		$display("with %0d-column records, a long sink hold-off, and text ending %s",
			REC_FIELDS, ending.name());
		if (bad_cnt == 0)
			$display("tb_csv_stream_tokenizer_core: PASS");
		else
			$display("tb_csv_stream_tokenizer_core: FAIL");
		$finish;
	end

endmodule

FILE: files.f
sv/cst_pkg.sv
sv/cst_parser.sv
sv/cst_result_fifo.sv
sv/csv_stream_tokenizer_core.sv
sv/cst_checker.sv
tb/sv/tb_csv_stream_tokenizer_core.sv
